// ----- sv/dfr_pkg.sv -----
// Package for the DLE frame receiver: constants, register map, controller
// states and the command/status bundles between controller and datapath.
// No dependencies.
package dfr_pkg;

    // Default frame buffer depth in bytes
    localparam int MAX_FRAME_LEN_DEF = 64;

    // Frame layout: the length byte sits at position two, the total frame
    // size is the length byte plus a fixed overhead
    localparam int LEN_INDEX    = 2;
    localparam int LEN_OVERHEAD = 7;

    // Widths of the fixed fields
    localparam int BYTE_W = 8;
    localparam int POS_W  = 6;
    // Enough for the largest frame length: 255 + overhead
    localparam int FLEN_W = 9;

    // Register map (word index) and reset values
    localparam int CFG_ADDR_W = 3;
    localparam logic [0:0] REG_ESCAPE_CODE = 1'b0;
    localparam logic [0:0] REG_START_CODE  = 1'b1;
    localparam logic [BYTE_W-1:0] ESCAPE_CODE_RST = 8'd16;
    localparam logic [BYTE_W-1:0] START_CODE_RST  = 8'd26;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HDR,
        ST_LOAD,
        ST_EMIT
    } dfr_state_t;

    // Controller to datapath
    typedef struct packed {
        logic take;     // accept the word on the input
        logic hdr_wr;   // write the start code at position one
        logic load;     // start a readout at position zero
        logic advance;  // step to the next stored byte
    } dfr_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic restart;  // input word completes an escape-start pair
        logic complete; // input word completes the frame
        logic last;     // readout is at the final byte
    } dfr_status_t;

endpackage

// ----- sv/dfr_if.sv -----
// Valid/ready channels of the DLE frame receiver: received bytes in,
// frame bytes out. No dependencies.
interface dfr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface dfr_frame_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic [5:0] byte_position;
    logic       frame_last;

    modport source (output valid, output frame_byte, output byte_position,
                    output frame_last, input ready);
    modport sink   (input valid, input frame_byte, input byte_position,
                    input frame_last, output ready);
endinterface

// ----- sv/dfr_ctrl.sv -----
// Controller state machine of the DLE frame receiver.
// Depends on dfr_pkg.
module dfr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  dfr_pkg::dfr_status_t status,
    output dfr_pkg::dfr_cmd_t    cmd
);
    import dfr_pkg::*;

    dfr_state_t state_reg;
    dfr_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    if (status.restart)
                    begin
                        state_next = ST_HDR;
                    end
                    else if (status.complete)
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_HDR:
            begin
                cmd.hdr_wr = 1'b1;
                state_next = ST_IDLE;
            end
            ST_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (status.last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/dfr_datapath.sv -----
// Datapath of the DLE frame receiver: escape decode, write position,
// frame buffer memory and readout index.
// Depends on dfr_pkg.
module dfr_datapath #(
    parameter int MAX_FRAME_LEN = dfr_pkg::MAX_FRAME_LEN_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  dfr_pkg::dfr_cmd_t           cmd,
    output dfr_pkg::dfr_status_t        status,
    input  logic [dfr_pkg::BYTE_W-1:0]  rx_byte,
    input  logic [dfr_pkg::BYTE_W-1:0]  escape_code,
    input  logic [dfr_pkg::BYTE_W-1:0]  start_code,
    output logic [dfr_pkg::BYTE_W-1:0]  frame_byte,
    output logic [dfr_pkg::POS_W-1:0]   byte_position,
    output logic                        frame_last
);
    import dfr_pkg::*;

    localparam int AW  = $clog2(MAX_FRAME_LEN);
    localparam int WPW = $clog2(MAX_FRAME_LEN + 1);
    localparam int LW  = ((WPW > FLEN_W) ? WPW : FLEN_W) + 1;

    logic [BYTE_W-1:0] mem [MAX_FRAME_LEN];
    logic [BYTE_W-1:0] mem_q_reg;

    logic [WPW-1:0]    wp_reg;
    logic [WPW-1:0]    wp_next;
    logic              esc_pend_reg;
    logic              esc_pend_next;
    logic [BYTE_W-1:0] lenb_reg;
    logic [AW-1:0]     last_reg;
    logic [AW-1:0]     idx_reg;

    logic              is_start;
    logic              is_dup;
    logic              do_store;
    logic [WPW-1:0]    wp_inc;
    logic              at_len;
    logic [BYTE_W-1:0] lenb_eff;
    logic [LW-1:0]     frame_len;
    logic [LW-1:0]     emit_cnt;
    logic              complete;
    logic              full;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [BYTE_W-1:0] mem_wdata;
    logic [AW-1:0]     rd_addr;

    // Decode the incoming byte against the escape state
    always_comb
    begin
        is_start  = esc_pend_reg && (rx_byte == start_code);
        is_dup    = esc_pend_reg && !is_start && (rx_byte == escape_code);
        do_store  = !is_start && !is_dup;
        wp_inc    = wp_reg + WPW'(1);
        at_len    = (wp_reg == WPW'(LEN_INDEX));
        lenb_eff  = at_len ? rx_byte : lenb_reg;
        frame_len = LW'(lenb_eff) + LW'(LEN_OVERHEAD);
        complete  = do_store && (wp_inc > WPW'(LEN_INDEX)) && (LW'(wp_inc) >= frame_len);
        full      = (wp_inc == WPW'(MAX_FRAME_LEN));
        emit_cnt  = (frame_len > LW'(MAX_FRAME_LEN)) ? LW'(MAX_FRAME_LEN) : frame_len;
    end

    // Next write position and escape flag
    always_comb
    begin
        wp_next       = wp_reg;
        esc_pend_next = esc_pend_reg;
        if (cmd.take)
        begin
            priority if (is_start)
            begin
                wp_next       = WPW'(LEN_INDEX);
                esc_pend_next = 1'b0;
            end
            else if (is_dup)
            begin
                esc_pend_next = 1'b0;
            end
            else if (complete || full)
            begin
                wp_next       = '0;
                esc_pend_next = 1'b0;
            end
            else
            begin
                wp_next       = wp_inc;
                esc_pend_next = (rx_byte == escape_code);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg       <= '0;
            esc_pend_reg <= 1'b0;
        end
        else
        begin
            wp_reg       <= wp_next;
            esc_pend_reg <= esc_pend_next;
        end
    end

    // Capture the length byte and the index of the final byte
    always_ff @(posedge clk)
    begin
        if (cmd.take && do_store && at_len)
        begin
            lenb_reg <= rx_byte;
        end
        if (cmd.take && complete)
        begin
            last_reg <= AW'(emit_cnt - LW'(1));
        end
    end

    // Select the buffer write: escape byte on restart, start code next cycle
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = wp_reg[AW-1:0];
        mem_wdata = rx_byte;
        if (cmd.hdr_wr)
        begin
            mem_we    = 1'b1;
            mem_waddr = AW'(1);
            mem_wdata = start_code;
        end
        else if (cmd.take && is_start)
        begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = escape_code;
        end
        else if (cmd.take && do_store && (wp_reg < WPW'(MAX_FRAME_LEN)))
        begin
            mem_we = 1'b1;
        end
    end

    // Read address: restart, step, or hold the current byte
    always_comb
    begin
        priority if (cmd.load)
        begin
            rd_addr = '0;
        end
        else if (cmd.advance)
        begin
            rd_addr = idx_reg + AW'(1);
        end
        else
        begin
            rd_addr = idx_reg;
        end
    end

    // Frame buffer with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_q_reg <= mem[rd_addr];
        idx_reg   <= rd_addr;
    end

    assign status.restart  = is_start;
    assign status.complete = complete;
    assign status.last     = (idx_reg == last_reg);

    assign frame_byte    = mem_q_reg;
    assign byte_position = POS_W'(idx_reg);
    assign frame_last    = (idx_reg == last_reg);

endmodule

// ----- sv/dle_frame_receiver.sv -----
// DLE frame receiver: one received byte per word in; a completed frame out
// as a burst of one stored byte per cycle while the output is ready. An ordinary
// input word is taken in the idle state; a start code after an escape also needs the
// header state (two buffer writes on one port). A completing word is followed by a
// load state, then the frame streams out; input is held off until the final byte is taken.
// Reset clears the control state and loads the escape and start codes; buffer
// contents stay undefined.
module dle_frame_receiver #(
    parameter int MAX_FRAME_LEN = dfr_pkg::MAX_FRAME_LEN_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    dfr_rx_if.sink                          rx,
    dfr_frame_if.source                     frame,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dfr_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);
    import dfr_pkg::*;

    logic [BYTE_W-1:0] escape_code_reg;
    logic [BYTE_W-1:0] start_code_reg;
    logic              cfg_wr;
    dfr_cmd_t          cmd;
    dfr_status_t       status;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_code_reg <= ESCAPE_CODE_RST;
            start_code_reg  <= START_CODE_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_ESCAPE_CODE: escape_code_reg <= pwdata[BYTE_W-1:0];
                REG_START_CODE:  start_code_reg  <= pwdata[BYTE_W-1:0];
                default:         escape_code_reg <= escape_code_reg;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        unique case (paddr[2])
            REG_ESCAPE_CODE: prdata = {24'd0, escape_code_reg};
            REG_START_CODE:  prdata = {24'd0, start_code_reg};
            default:         prdata = '0;
        endcase
    end

    dfr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rx.valid),
        .in_ready  (rx.ready),
        .out_valid (frame.valid),
        .out_ready (frame.ready),
        .status    (status),
        .cmd       (cmd)
    );

    dfr_datapath #(
        .MAX_FRAME_LEN (MAX_FRAME_LEN)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .rx_byte       (rx.rx_byte),
        .escape_code   (escape_code_reg),
        .start_code    (start_code_reg),
        .frame_byte    (frame.frame_byte),
        .byte_position (frame.byte_position),
        .frame_last    (frame.frame_last)
    );

    // Input is never taken while a frame is being emitted
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(rx.ready && frame.valid))
        else $error("input ready during frame readout");

    // After the final byte the receiver returns to taking input
    a_last_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (frame.valid && frame.ready && frame.frame_last) |=> rx.ready)
        else $error("receiver not idle after final byte");

    // Positions within a burst step by one
    a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
        (frame.valid && frame.ready && !frame.frame_last) |=>
        (frame.valid && (frame.byte_position == $past(frame.byte_position) + 6'd1)))
        else $error("byte position did not advance by one");

endmodule
